FILE: rtl/core/ipp_pkg.sv
// Package for the inertial-sensor packet parser.
// Holds the byte codes and positions, phase and kind types, the frame and yaw control structs, and to_count.
// No dependencies.
package ipp_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    localparam logic [3:0] POS_FIRST_DATA = 4'd2;
    localparam logic [3:0] POS_LAST_DATA  = 4'd7;
    localparam logic [3:0] POS_YAW_READY  = 4'd8;
    localparam logic [3:0] POS_CHECKSUM   = 4'd10;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TYPE  = 3'd1,
        PH_ANGLE = 3'd2,
        PH_RATE  = 3'd3,
        PH_ACCEL = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } t_kind;

    typedef struct packed {
        logic        done;
        logic        ok;
        t_kind       kind;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
    } t_frame;

    typedef struct packed {
        logic load;
        logic commit;
    } t_yaw_ctl;

    function automatic logic signed [16:0] to_count(input logic [15:0] raw);
        logic signed [16:0] res;
        if (raw > 16'h8000) begin
            res = {1'b1, raw};
        end else begin
            res = {1'b0, raw};
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/imu_uart_packet_parser_unit.sv
// Top level of the inertial-sensor packet parser: framer, yaw unit, result register.
// Depends on ipp_pkg, ipp_framer and ipp_yaw.
//
//   Channel  Direction  Handshake                  Payload
//   rx       in         i_rx_valid / o_rx_ready    i_rx_byte
//   res      out        o_res_valid / i_res_ready  kind, checksum flag, x, y, z, yaw total
//
// One byte is taken per cycle while o_rx_ready is high; a result appears in the cycle after its checksum byte.
// The framer state and payload bytes form the input side; the result register the output.
// The yaw delta is formed two bytes before the checksum, so the last byte needs one add.
// Only a checksum byte waits on a full result register; other bytes always pass.
// Reset returns the framer to header search and clears the yaw accumulator.
module imu_uart_packet_parser_unit
    import ipp_pkg::*;
#(
    parameter int YAW_ACC_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [1:0]         o_packet_kind,
    output logic               o_checksum_ok,
    output logic signed [16:0] o_value_x,
    output logic signed [16:0] o_value_y,
    output logic signed [16:0] o_value_z,
    output logic signed [31:0] o_yaw_total
);

    logic               accept;
    logic               last_pending;
    t_frame             frame;
    t_yaw_ctl           yaw_ctl;
    logic signed [31:0] yaw_total;

    logic               r_valid;
    logic [1:0]         r_kind;
    logic               r_ok;
    logic signed [16:0] r_x, r_y, r_z;
    logic signed [31:0] r_yaw;

    assign o_rx_ready = !last_pending || !r_valid || i_res_ready;
    assign accept     = i_rx_valid && o_rx_ready;

    ipp_framer u_framer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte         (i_rx_byte),
        .o_last_pending (last_pending),
        .o_frame        (frame),
        .o_yaw_ctl      (yaw_ctl)
    );

    ipp_yaw #(
        .YAW_ACC_WIDTH (YAW_ACC_WIDTH)
    ) u_yaw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (yaw_ctl),
        .i_yaw       (frame.w2),
        .o_yaw_total (yaw_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (frame.done) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame.done) begin
            r_kind <= frame.kind;
            r_ok   <= frame.ok;
            r_x    <= frame.ok ? to_count(frame.w0) : '0;
            r_y    <= frame.ok ? to_count(frame.w1) : '0;
            r_z    <= frame.ok ? to_count(frame.w2) : '0;
            r_yaw  <= yaw_total;
        end
    end

    assign o_res_valid   = r_valid;
    assign o_packet_kind = r_kind;
    assign o_checksum_ok = r_ok;
    assign o_value_x     = r_x;
    assign o_value_y     = r_y;
    assign o_value_z     = r_z;
    assign o_yaw_total   = r_yaw;

    a_ready_only_blocked_by_full_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> (o_res_valid && !i_res_ready)
    ) else $error("Input stalled while the result register could take a transaction.");

    a_done_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        frame.done |=> o_res_valid
    ) else $error("Completed packet did not produce a result transaction.");

    a_failed_checksum_zero_values: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_checksum_ok) |->
            (o_value_x == 17'sd0 && o_value_y == 17'sd0 && o_value_z == 17'sd0)
    ) else $error("Result with failed checksum carries nonzero values.");

endmodule

FILE: rtl/core/ipp_framer.sv
// Byte framer of the packet parser: header, type, payload and checksum tracking.
// Depends on ipp_pkg.
module ipp_framer
    import ipp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_last_pending,
    output t_frame     o_frame,
    output t_yaw_ctl   o_yaw_ctl
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_payload [6];
    logic       data_phase;
    logic [2:0] wr_idx;
    logic       wr_en;

    assign data_phase     = (r_phase == PH_ANGLE) || (r_phase == PH_RATE) ||
                            (r_phase == PH_ACCEL);
    assign o_last_pending = data_phase && (r_pos >= POS_CHECKSUM);
    assign wr_idx         = 3'(r_pos - POS_FIRST_DATA);
    assign wr_en          = i_accept && data_phase && (r_pos >= POS_FIRST_DATA) &&
                            (r_pos <= POS_LAST_DATA);

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_sum   = r_sum;
        o_frame.done = i_accept && o_last_pending;
        o_frame.ok   = (r_sum == i_byte);
        case (r_phase)
            PH_ACCEL: o_frame.kind = KIND_ACCEL;
            PH_RATE:  o_frame.kind = KIND_RATE;
            default:  o_frame.kind = KIND_ANGLE;
        endcase
        o_frame.w0 = {r_payload[1], r_payload[0]};
        o_frame.w1 = {r_payload[3], r_payload[2]};
        o_frame.w2 = {r_payload[5], r_payload[4]};
        o_yaw_ctl.load   = i_accept && data_phase && (r_pos == POS_YAW_READY);
        o_yaw_ctl.commit = o_frame.done && o_frame.ok && (o_frame.kind == KIND_ANGLE);
        if (i_accept) begin
            if (r_phase == PH_TYPE) begin
                if (i_byte == TYPE_ANGLE || i_byte == TYPE_RATE || i_byte == TYPE_ACCEL) begin
                    n_phase = (i_byte == TYPE_ANGLE) ? PH_ANGLE :
                              (i_byte == TYPE_RATE) ? PH_RATE : PH_ACCEL;
                    n_sum   = r_sum + i_byte;
                    n_pos   = POS_FIRST_DATA;
                end
            end else if (data_phase) begin
                if (r_pos < POS_CHECKSUM) begin
                    n_sum = r_sum + i_byte;
                    n_pos = r_pos + 4'd1;
                end else begin
                    n_phase = PH_IDLE;
                    n_pos   = '0;
                    n_sum   = '0;
                end
            end else if (i_byte == HDR_BYTE) begin
                n_phase = PH_TYPE;
                n_sum   = i_byte;
                n_pos   = 4'd1;
            end else begin
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_payload[wr_idx] <= i_byte;
        end
    end

endmodule

FILE: rtl/core/ipp_yaw.sv
// Yaw unwrapping and saturating accumulation for angle packets.
// Depends on ipp_pkg.
module ipp_yaw
    import ipp_pkg::*;
#(
    parameter int YAW_ACC_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_yaw_ctl           i_ctl,
    input  logic [15:0]        i_yaw,
    output logic signed [31:0] o_yaw_total
);

    localparam int W    = YAW_ACC_WIDTH;
    localparam int OUTW = (W < 32) ? W : 32;

    localparam logic signed [W:0] ACC_MAX = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W:0] ACC_MIN = {2'b11, {(W-1){1'b0}}};
    localparam logic signed [W:0] OUT_MAX = {{(W+2-OUTW){1'b0}}, {(OUTW-1){1'b1}}};
    localparam logic signed [W:0] OUT_MIN = {{(W+2-OUTW){1'b1}}, {(OUTW-1){1'b0}}};

    logic signed [W-1:0] r_acc, n_acc;
    logic        [15:0]  r_prev;
    logic signed [16:0]  r_delta, n_delta;
    logic signed [17:0]  diff;
    logic signed [W:0]   sum;
    logic signed [W:0]   clamped;

    always_comb begin
        diff = $signed({2'b00, i_yaw}) - $signed({2'b00, r_prev});
        if (diff > 18'sd32768) begin
            diff = diff - 18'sd65536;
        end else if (diff < -18'sd32768) begin
            diff = diff + 18'sd65536;
        end
        n_delta = diff[16:0];
    end

    always_comb begin
        sum = {r_acc[W-1], r_acc};
        if (i_ctl.commit) begin
            sum = sum + (W+1)'(r_delta);
        end
        if (sum[W] != sum[W-1]) begin
            n_acc = sum[W] ? ACC_MIN[W-1:0] : ACC_MAX[W-1:0];
        end else begin
            n_acc = sum[W-1:0];
        end
        if (sum > OUT_MAX) begin
            clamped = OUT_MAX;
        end else if (sum < OUT_MIN) begin
            clamped = OUT_MIN;
        end else begin
            clamped = sum;
        end
        o_yaw_total = 32'(clamped);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_prev <= '0;
        end else if (i_ctl.commit) begin
            r_acc  <= n_acc;
            r_prev <= i_yaw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_delta <= n_delta;
        end
    end

endmodule
